// ===== hw/rtl/lfbc_pkg.sv =====
package lfbc_pkg;

  localparam int KEY_W   = 16;
  localparam int LEN_W   = 17;
  localparam int BB_W    = 17;
  localparam int RING_W  = 11;
  localparam int OFF_W   = 32;
  localparam int SLOT_W  = 10;
  localparam int OCC_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [BB_W-1:0]   BB_RESET   = BB_W'(4096);
  localparam logic [RING_W-1:0] RING_RESET = RING_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 1'b1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    EV_TRIM   = 2'd0,
    EV_EVICT  = 2'd1,
    EV_LOOKUP = 2'd2
  } ev_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EVAL1,
    ST_EVAL2,
    ST_WRITE
  } state_e;

  // One ring slot as stored in the slot memory.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_ent_t;

  // One result waiting in the output queue.
  typedef struct packed {
    ev_kind_e          kind;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } res_t;

endpackage

// ===== hw/rtl/lfbc_ram.sv =====
module lfbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/lfbc_res_fifo.sv =====
module lfbc_res_fifo import lfbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t item_i,
  output logic room2_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t item_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  res_t              buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]    cnt_q, cnt_d;
  logic              pop;

  assign valid_o  = (cnt_q != '0);
  assign item_o   = buf_q[rd_q];
  assign room2_o  = (cnt_q <= (PTR_W+1)'(DEPTH - 2));
  assign pop      = valid_o && ready_i;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/log_fifo_block_cache.sv =====
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    operation_i, block_key_i, write_length_i
// output    out_valid_o / out_ready_i  event_kind_o, event_key_o, byte_offset_o,
//                                      byte_length_o, hit_o, slot_o, occupancy_o, last_o
// config    cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// An insert steps through a map and slot read, a dependent map read of the evicted
// key and two map writes on the single map write port; a lookup needs only the map read.
// After reset a clearing pass writes every entry of the key map and slot ring while
// in_ready_o stays low.
// Results queue in a 4-entry buffer; a new transaction is taken while at least
// two entries are free, so a stalled output side only stalls input once fewer are free.
// KEY_SPACE is a power of two: the map is indexed by the low key bits.
module log_fifo_block_cache import lfbc_pkg::*; #(
  parameter int LOG_DEPTH = 1024,
  parameter int KEY_SPACE = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [KEY_W-1:0]      block_key_i,
  input  logic [LEN_W-1:0]      write_length_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            event_kind_o,
  output logic [KEY_W-1:0]      event_key_o,
  output logic [OFF_W-1:0]      byte_offset_o,
  output logic [LEN_W-1:0]      byte_length_o,
  output logic                  hit_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [OCC_W-1:0]      occupancy_o,
  output logic                  last_o
);

  localparam int PW    = $clog2(LOG_DEPTH);
  localparam int KAW   = $clog2(KEY_SPACE);
  localparam int MAP_N = 2 ** KAW;
  localparam int MEW   = PW + 1;
  localparam int CNTW  = PW + 1;
  localparam int CW    = (PW + 1 > RING_W) ? PW + 1 : RING_W;
  localparam int CLR_N = (MAP_N > LOG_DEPTH) ? MAP_N : LOG_DEPTH;
  localparam int CLRW  = $clog2(CLR_N);

  state_e state_q, state_d;
  logic [CLRW-1:0] clr_q, clr_d;
  logic [PW-1:0]   wp_q, wp_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [BB_W-1:0]   bb_q;
  logic [RING_W-1:0] ring_q;

  // per-item payload registers
  logic [KEY_W-1:0] key_q;
  logic [LEN_W-1:0] wlen_q;
  logic [PW-1:0]    wp_use_q;
  logic             maphit_q, evict_q;
  logic [KEY_W-1:0] oldkey_q;

  // memories
  logic            map_we, slot_we;
  logic [KAW-1:0]  map_waddr, map_raddr;
  logic [MEW-1:0]  map_wdata, map_rdata;
  logic [PW-1:0]   slot_waddr, slot_raddr;
  slot_ent_t       slot_wdata, slot_rdata;
  logic            map_rd_vld;
  logic [PW-1:0]   map_rd_slot;

  // ring bounds
  logic [CW-1:0] ring_ext, ring_eff, wp_nxt_ext;
  logic [PW-1:0] wp_eff;

  logic       accept, room2, push, unmap, slot_live;
  logic [KAW-1:0] mk_in, mk_q, om;
  res_t       push_item, head;
  logic       fifo_valid;
  logic [KEY_W+BB_W-1:0] prod;

  assign map_rd_vld  = map_rdata[PW];
  assign map_rd_slot = map_rdata[PW-1:0];
  assign mk_in       = KAW'(block_key_i);
  assign mk_q        = KAW'(key_q);
  assign om          = KAW'(slot_rdata.key);

  always_comb begin
    ring_ext = CW'(ring_q);
    if (ring_ext == '0) begin
      ring_eff = CW'(1);
    end else if (ring_ext > CW'(LOG_DEPTH)) begin
      ring_eff = CW'(LOG_DEPTH);
    end else begin
      ring_eff = ring_ext;
    end
    // a pointer left outside a shrunk ring restarts at slot zero
    wp_eff     = (CW'(wp_q) >= ring_eff) ? '0 : wp_q;
    wp_nxt_ext = CW'(wp_use_q) + CW'(1);
  end

  // slot under the pointer is live unless this insert just freed it
  assign slot_live = slot_rdata.valid && !(map_rd_vld && (map_rd_slot == wp_use_q));
  assign unmap = evict_q && map_rd_vld && (map_rd_slot == wp_use_q) && (om != mk_q);

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    map_raddr  = mk_in;
    slot_raddr = wp_eff;
    map_we     = 1'b0;
    map_waddr  = mk_q;
    map_wdata  = '0;
    slot_we    = 1'b0;
    slot_waddr = wp_use_q;
    slot_wdata = '0;
    push       = 1'b0;
    push_item  = '0;

    case (state_q)
      ST_CLEAR: begin
        map_we     = ((CLRW+1)'(clr_q) < (CLRW+1)'(MAP_N));
        map_waddr  = clr_q[KAW-1:0];
        slot_we    = ((CLRW+1)'(clr_q) < (CLRW+1)'(LOG_DEPTH));
        slot_waddr = clr_q[PW-1:0];
        clr_d      = clr_q + 1'b1;
        if (clr_q == CLRW'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = room2;
        if (accept) begin
          state_d = (operation_i == OP_LOOKUP) ? ST_LOOK : ST_EVAL1;
        end
      end
      ST_LOOK: begin
        push           = 1'b1;
        push_item.kind = EV_LOOKUP;
        push_item.key  = key_q;
        push_item.hit  = map_rd_vld;
        push_item.slot = map_rd_vld ? SLOT_W'(map_rd_slot) : '0;
        push_item.occ  = OCC_W'(cnt_q);
        push_item.last = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_EVAL1: begin
        // fetch the map entry of the key that is about to be evicted
        map_raddr = om;
        if (map_rd_vld && (map_rd_slot != wp_use_q)) begin
          slot_we    = 1'b1;
          slot_waddr = map_rd_slot;
        end
        state_d = ST_EVAL2;
      end
      ST_EVAL2: begin
        cnt_d = cnt_q - CNTW'(maphit_q) - CNTW'(unmap) + CNTW'(1);
        if (unmap) begin
          map_we    = 1'b1;
          map_waddr = KAW'(oldkey_q);
        end
        slot_we          = 1'b1;
        slot_wdata.valid = 1'b1;
        slot_wdata.key   = key_q;
        if (!maphit_q) begin
          push           = 1'b1;
          push_item.kind = EV_TRIM;
          push_item.key  = key_q;
          push_item.len  = wlen_q;
          push_item.occ  = OCC_W'(cnt_d);
          push_item.last = !evict_q;
        end
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        map_we    = 1'b1;
        map_wdata = {1'b1, wp_use_q};
        wp_d      = (wp_nxt_ext >= ring_eff) ? '0 : PW'(wp_nxt_ext);
        if (evict_q) begin
          push           = 1'b1;
          push_item.kind = EV_EVICT;
          push_item.key  = oldkey_q;
          push_item.len  = bb_q;
          push_item.occ  = OCC_W'(cnt_q);
          push_item.last = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      cnt_q   <= '0;
      bb_q    <= BB_RESET;
      ring_q  <= RING_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_BYTES: bb_q   <= cfg_data_i;
          CFG_RING_SIZE:   ring_q <= cfg_data_i[RING_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= block_key_i;
      wlen_q   <= write_length_i;
      wp_use_q <= wp_eff;
    end
    if (state_q == ST_EVAL1) begin
      maphit_q <= map_rd_vld;
      evict_q  <= slot_live;
      oldkey_q <= slot_rdata.key;
    end
  end

  lfbc_ram #(.WIDTH(MEW), .DEPTH(MAP_N)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  lfbc_ram #(.WIDTH($bits(slot_ent_t)), .DEPTH(LOG_DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  lfbc_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .room2_o  (room2),
    .valid_o  (fifo_valid),
    .ready_i  (out_ready_i),
    .item_o   (head)
  );

  // block_bytes must stay stable while results wait (the block does not enforce this), so scale at the queue head
  assign prod = (KEY_W+BB_W)'(head.key) * (KEY_W+BB_W)'(bb_q);

  assign out_valid_o   = fifo_valid;
  assign event_kind_o  = head.kind;
  assign event_key_o   = head.key;
  assign byte_offset_o = prod[OFF_W-1:0];
  assign byte_length_o = head.len;
  assign hit_o         = head.hit;
  assign slot_o        = head.slot;
  assign occupancy_o   = head.occ;
  assign last_o        = head.last;

endmodule

// ===== hw/rtl/lfbc_checker.sv =====
module lfbc_checker import lfbc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  operation_i,
  input logic [KEY_W-1:0]      block_key_i,
  input logic [LEN_W-1:0]      write_length_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [1:0]            event_kind_o,
  input logic [KEY_W-1:0]      event_key_o,
  input logic [OFF_W-1:0]      byte_offset_o,
  input logic [LEN_W-1:0]      byte_length_o,
  input logic                  hit_o,
  input logic [SLOT_W-1:0]     slot_o,
  input logic [OCC_W-1:0]      occupancy_o,
  input logic                  last_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(event_key_o) && $stable(event_kind_o)
      && $stable(last_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  a_lookup_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_LOOKUP) |->
      (byte_length_o == '0) && last_o && (hit_o || (slot_o == '0)))
    else $error("lookup reply fields inconsistent");

  a_event_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((event_kind_o == EV_TRIM) || (event_kind_o == EV_EVICT)) |->
      !hit_o && (slot_o == '0))
    else $error("trim or eviction carries lookup fields");

  a_evict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_EVICT) |-> last_o)
    else $error("eviction is not the final result of its insert");

endmodule

bind log_fifo_block_cache lfbc_checker u_lfbc_checker (.*);

// ===== verif/tb_log_fifo_block_cache.sv =====
module tb_log_fifo_block_cache import lfbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_DEPTH = 1024;
  localparam int KEY_SPACE = 65536;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    ev_kind_e          kind;
    logic [KEY_W-1:0]  key;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } cache_event_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic                  op;
    logic [KEY_W-1:0]      key;
    logic [LEN_W-1:0]      wlen;
    logic                  typed;
    cache_event_t          ev;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [KEY_W-1:0]      block_key_i;
  logic [LEN_W-1:0]      write_length_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            event_kind_o;
  logic [KEY_W-1:0]      event_key_o;
  logic [OFF_W-1:0]      byte_offset_o;
  logic [LEN_W-1:0]      byte_length_o;
  logic                  hit_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [OCC_W-1:0]      occupancy_o;
  logic                  last_o;

  log_fifo_block_cache #(
    .LOG_DEPTH(LOG_DEPTH),
    .KEY_SPACE(KEY_SPACE)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .block_key_i    (block_key_i),
    .write_length_i (write_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .event_key_o    (event_key_o),
    .byte_offset_o  (byte_offset_o),
    .byte_length_o  (byte_length_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .occupancy_o    (occupancy_o),
    .last_o         (last_o)
  );

  // Shadow copy of the cache state
  logic [KEY_W-1:0]  ring_key  [LOG_DEPTH];
  bit                ring_live [LOG_DEPTH];
  logic [SLOT_W-1:0] key_slot  [KEY_SPACE];
  bit                key_live  [KEY_SPACE];
  int unsigned       wptr;
  int unsigned       live_count;
  logic [BB_W-1:0]   bb_cfg;
  logic [RING_W-1:0] ring_cfg;

  cache_event_t step_events[$];
  cache_event_t pending_events[$];
  int           mismatches;
  bit           hold_req;
  int           send_calm;
  int           recv_calm;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic void push_event(ev_kind_e kind, logic [KEY_W-1:0] key,
                                     logic [LEN_W-1:0] len, logic hit,
                                     logic [SLOT_W-1:0] slot);
    cache_event_t ev;
    ev.kind = kind;
    ev.key  = key;
    ev.off  = 32'(key) * 32'(bb_cfg);
    ev.len  = len;
    ev.hit  = hit;
    ev.slot = slot;
    ev.occ  = '0;
    ev.last = 1'b0;
    step_events.push_back(ev);
  endfunction

  function automatic void cache_step(logic op, logic [KEY_W-1:0] key, logic [LEN_W-1:0] wlen);
    int unsigned ring;
    int unsigned wp;
    int unsigned mk;
    int unsigned victim;
    step_events.delete();
    mk = key % KEY_SPACE;
    if (op == OP_LOOKUP) begin
      push_event(EV_LOOKUP, key, '0, key_live[mk], key_live[mk] ? key_slot[mk] : '0);
    end else begin
      ring = (ring_cfg == 0) ? 1 : ((ring_cfg > LOG_DEPTH) ? LOG_DEPTH : ring_cfg);
      // a pointer left outside a shrunken ring restarts at slot 0
      wp = (wptr >= ring) ? 0 : wptr;
      if (key_live[mk]) begin
        ring_live[key_slot[mk] % LOG_DEPTH] = 1'b0;
        key_live[mk] = 1'b0;
        live_count--;
      end else begin
        push_event(EV_TRIM, key, wlen, 1'b0, '0);
      end
      if (ring_live[wp]) begin
        victim = ring_key[wp] % KEY_SPACE;
        // unmap only if the map still points here
        if (key_live[victim] && key_slot[victim] == SLOT_W'(wp)) begin
          key_live[victim] = 1'b0;
          live_count--;
        end
        ring_live[wp] = 1'b0;
        push_event(EV_EVICT, ring_key[wp], bb_cfg, 1'b0, '0);
      end
      ring_key[wp]  = key;
      ring_live[wp] = 1'b1;
      key_slot[mk]  = SLOT_W'(wp);
      key_live[mk]  = 1'b1;
      live_count++;
      wptr = (wp + 1 >= ring) ? 0 : wp + 1;
    end
    foreach (step_events[i]) begin
      step_events[i].occ  = OCC_W'(live_count);
      step_events[i].last = (i == step_events.size() - 1);
    end
  endfunction

  function automatic stim_row_t item(logic op, logic [KEY_W-1:0] key, logic [LEN_W-1:0] wlen);
    stim_row_t r;
    r = '0;
    r.op   = op;
    r.key  = key;
    r.wlen = wlen;
    return r;
  endfunction

  function automatic stim_row_t checked(logic op, logic [KEY_W-1:0] key,
                                        logic [LEN_W-1:0] wlen, ev_kind_e kind,
                                        logic [OFF_W-1:0] off, logic [LEN_W-1:0] len,
                                        logic hit, logic [SLOT_W-1:0] slot,
                                        logic [OCC_W-1:0] occ);
    stim_row_t r;
    r = item(op, key, wlen);
    r.typed   = 1'b1;
    r.ev.kind = kind;
    r.ev.key  = key;
    r.ev.off  = off;
    r.ev.len  = len;
    r.ev.hit  = hit;
    r.ev.slot = slot;
    r.ev.occ  = occ;
    r.ev.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Mostly random waits, with occasional runs of back-to-back transactions
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  function automatic string show(cache_event_t ev);
    return $sformatf("kind=%0d key=%h off=%h len=%h hit=%b slot=%0d occ=%0d last=%b",
                     ev.kind, ev.key, ev.off, ev.len, ev.hit, ev.slot, ev.occ, ev.last);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(stim_row_t r);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    operation_i    = r.op;
    block_key_i    = r.key;
    write_length_i = r.wlen;
    do @(posedge clk_i); while (!in_ready_o);
    cache_step(r.op, r.key, r.wlen);
    if (r.typed) pending_events.push_back(r.ev);
    else foreach (step_events[i]) pending_events.push_back(step_events[i]);
    @(negedge clk_i);
  endtask

  // Wait for the block to go idle, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    // an insert with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    if (idx == CFG_BLOCK_BYTES) bb_cfg = BB_W'(val);
    else if (idx == CFG_RING_SIZE) ring_cfg = RING_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic check_event();
    cache_event_t got;
    cache_event_t want;
    got.kind = ev_kind_e'(event_kind_o);
    got.key  = event_key_o;
    got.off  = byte_offset_o;
    got.len  = byte_length_o;
    got.hit  = hit_o;
    got.slot = slot_o;
    got.occ  = occupancy_o;
    got.last = last_o;
    if (pending_events.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected event: %s", $realtime, show(got));
    end else begin
      want = pending_events.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] event mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    recv_calm   = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i = 1'b0;
        hold_req    = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_event();
      @(negedge clk_i);
    end
  end

  initial begin
    stim_row_t        directed[$];
    int               ring_plan[6];
    int               bb_plan[6];
    int unsigned      ring;
    int unsigned      span;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    logic             op;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    operation_i    = OP_INSERT;
    block_key_i    = '0;
    write_length_i = '0;
    hold_req       = 1'b0;
    send_calm      = 0;
    mismatches     = 0;
    wptr           = 0;
    live_count     = 0;
    bb_cfg         = BB_RESET;
    ring_cfg       = RING_RESET;
    foreach (ring_key[i]) begin
      ring_key[i]  = '0;
      ring_live[i] = 1'b0;
    end
    foreach (key_slot[i]) begin
      key_slot[i] = '0;
      key_live[i] = 1'b0;
    end

    // Reset defaults: 4096-byte blocks, full ring
    directed.push_back(checked(OP_LOOKUP, 16'h0000, '0, EV_LOOKUP, '0, '0, 1'b0, '0, '0));
    directed.push_back(checked(OP_LOOKUP, 16'hFFFF, '0, EV_LOOKUP, 32'h0FFF_F000, '0,
                               1'b0, '0, 11'd0));
    directed.push_back(checked(OP_INSERT, 16'hFFFF, 17'h10000, EV_TRIM, 32'h0FFF_F000,
                               17'h10000, 1'b0, '0, 11'd1));
    directed.push_back(checked(OP_INSERT, 16'h0000, 17'h00000, EV_TRIM, '0, '0,
                               1'b0, '0, 11'd2));
    directed.push_back(checked(OP_LOOKUP, 16'hFFFF, '0, EV_LOOKUP, 32'h0FFF_F000, '0,
                               1'b1, 10'd0, 11'd2));
    directed.push_back(item(OP_INSERT, 16'hFFFF, 17'd5));  // rewrite: old slot dropped
    directed.push_back(checked(OP_LOOKUP, 16'hFFFF, '0, EV_LOOKUP, 32'h0FFF_F000, '0,
                               1'b1, 10'd2, 11'd2));
    // Shrink ring under the pointer, largest block size
    directed.push_back(reg_write(CFG_RING_SIZE, 17'd2));
    directed.push_back(reg_write(CFG_BLOCK_BYTES, 17'd65536));
    directed.push_back(item(OP_INSERT, 16'h0007, 17'd100));
    directed.push_back(item(OP_INSERT, 16'h0008, 17'd1));     // trim then eviction
    directed.push_back(item(OP_INSERT, 16'h0007, 17'd2));     // mapped at pointer: silent
    directed.push_back(item(OP_INSERT, 16'h1234, 17'h0FFFF));
    directed.push_back(item(OP_LOOKUP, 16'hFFFF, 17'h1FFFF)); // still mapped outside ring
    // Ring of zero acts as one; oversized block bytes overflow the offset
    directed.push_back(reg_write(CFG_RING_SIZE, 17'd0));
    directed.push_back(reg_write(CFG_BLOCK_BYTES, 17'h1FFFF));
    directed.push_back(item(OP_INSERT, 16'hFFFF, 17'd7));
    directed.push_back(item(OP_INSERT, 16'hABCD, 17'd9));
    directed.push_back(item(OP_LOOKUP, 16'hABCD, 17'd0));
    directed.push_back(reg_write(CFG_BLOCK_BYTES, 17'd0));
    directed.push_back(item(OP_INSERT, 16'h5555, 17'h10000));
    directed.push_back(item(OP_INSERT, 16'hAAAA, 17'h0AAAA));
    // Oversized ring saturates to the full depth
    directed.push_back(reg_write(CFG_RING_SIZE, 17'd2047));
    directed.push_back(reg_write(CFG_BLOCK_BYTES, 17'd1));
    directed.push_back(item(OP_INSERT, 16'h8000, 17'h15555));
    directed.push_back(item(OP_INSERT, 16'h7FFF, 17'h0FFFF));
    directed.push_back(item(OP_LOOKUP, 16'h8000, 17'd0));
    directed.push_back(item(OP_LOOKUP, 16'h5555, 17'd0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[r]) begin
      if (directed[r].is_cfg) write_reg(directed[r].cfg_idx, directed[r].cfg_val);
      else send_item(directed[r]);
    end

    ring_plan = '{3, 1, 16, 1024, 0, 2047};
    bb_plan   = '{$urandom_range(1, 65536), 65536, 512, 1, 0, 131071};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_RING_SIZE, CFG_DATA_W'(ring_plan[ph]));
      write_reg(CFG_BLOCK_BYTES, CFG_DATA_W'(bb_plan[ph]));
      // hold the result side long enough to back up the input
      if (ph == 2) hold_req = 1'b1;
      ring = (ring_plan[ph] == 0) ? 1 :
             ((ring_plan[ph] > LOG_DEPTH) ? LOG_DEPTH : ring_plan[ph]);
      span = (ring < 64) ? 2 * ring + 1 : 200;
      base = KEY_W'($urandom_range(0, 65535));
      repeat (150) begin
        if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom_range(0, 65535));
        else key = KEY_W'(base + $urandom_range(0, span));
        op = ($urandom_range(0, 9) < 3) ? OP_LOOKUP : OP_INSERT;
        send_item(item(op, key, LEN_W'($urandom_range(0, 65536))));
      end
    end

    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
